/* hdl/sps_pkg.sv */
// Shared types and constants of the shortest path search block.
// Depends on nothing; the interfaces and the top module import it.
package sps_pkg;

	localparam int CMD_W    = 2;
	localparam int NODE_W   = 6;
	localparam int CNT_W    = 7;
	localparam int STATUS_W = 2;
	localparam int FIELD_W  = 16;
	localparam int PRED_W   = 7;

	localparam logic [CMD_W-1:0] CMD_SET_POS = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLR_EDGE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FIND    = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_PATH    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_PATH = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

	localparam logic [PRED_W-1:0] PRED_NONE = 7'd127;
	localparam logic [CNT_W-1:0]  PATH_MAX  = 7'd63;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [NODE_W-1:0]   node_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [CNT_W-1:0]    count_t;

endpackage

/* hdl/sps_if.sv */
// Valid/ready channel interfaces of the shortest path search block.
// Depends on sps_pkg for the field types.
interface sps_req_if import sps_pkg::*; ();
	logic                      valid;
	logic                      ready;
	cmd_t                      cmd;
	node_t                     node_a;
	node_t                     node_b;
	logic signed [FIELD_W-1:0] pos_x;
	logic signed [FIELD_W-1:0] pos_y;
	logic signed [FIELD_W-1:0] pos_z;
	modport source (output valid, cmd, node_a, node_b, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, cmd, node_a, node_b, pos_x, pos_y, pos_z, output ready);
endinterface

interface sps_rsp_if import sps_pkg::*; ();
	logic    valid;
	logic    ready;
	node_t   path_node;
	status_t status;
	logic    last;
	modport source (output valid, path_node, status, last, input ready);
	modport sink (input valid, path_node, status, last, output ready);
endinterface

interface sps_cfg_if import sps_pkg::*; ();
	logic   valid;
	logic   ready;
	count_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* hdl/sps_weight.sv */
// Edge weight unit: squared Euclidean distance of two stored positions.
// One shared multiplier, one coordinate per cycle; uses no package items.
module sps_weight #(
	parameter int CW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [3*CW-1:0] pos_a,
	input  logic [3*CW-1:0] pos_b,
	output logic            done,
	output logic [2*CW+3:0] weight
);

	localparam int WW = 2 * CW + 4;

	logic [CW:0]     mag_q [3];
	logic [WW-1:0]   acc_q;
	logic [1:0]      k_q;
	logic            busy_q;
	logic            done_q;
	logic [CW:0]     mag_d [3];
	logic [CW:0]     mag_sel;
	logic [2*CW+1:0] sq;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [CW:0] d;
			d = $signed({pos_a[k*CW+CW-1], pos_a[k*CW +: CW]})
				- $signed({pos_b[k*CW+CW-1], pos_b[k*CW +: CW]});
			mag_d[k] = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
		end
	end

	always_comb begin
		case (k_q)
			2'd0: mag_sel = mag_q[0];
			2'd1: mag_sel = mag_q[1];
			default: mag_sel = mag_q[2];
		endcase
		sq = (2*CW+2)'(mag_sel) * (2*CW+2)'(mag_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= 2'd0;
			end else if (busy_q) begin
				if (k_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				k_q <= k_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int k = 0; k < 3; k++) mag_q[k] <= mag_d[k];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + WW'(sq);
		end
	end

	assign done   = done_q;
	assign weight = acc_q;

endmodule

/* hdl/shortest_path_search_top.sv */
// Top level of the shortest path search block: command decode, graph memories,
// Dijkstra sequencer and result register. Depends on sps_pkg, sps_if, sps_weight.
//
// Usage. Items arrive on req; a transfer happens when valid and ready are high.
// Set position and clear edges finish at dispatch; add edge reads and writes the
// adjacency rows of both nodes. A path query first checks its indices (a status
// result if they are out of range or equal), then runs Dijkstra over cnt =
// min(node_count, NODES) nodes. Each step scans the distance memory for the
// nearest unvisited node, then walks the chosen node's adjacency row and relaxes
// each unvisited neighbor with one weight multiply per coordinate. The path is
// then traced back through the predecessors and emitted.
// req.ready is high only between items. Results leave through one output
// register on rsp; a stalled receiver holds the register and the sequencer
// waits before each further result. cfg writes node_count and is always ready.
// Reset clears all edges, sets node_count to 64 and empties the result register;
// positions are undefined until written.
module shortest_path_search_top import sps_pkg::*; #(
	parameter int NODES = 64,
	parameter int COORD_WIDTH = 16,
	parameter int DIST_WIDTH = 48
) (
	input logic      clk,
	input logic      arst_n,
	sps_req_if.sink  req,
	sps_rsp_if.source rsp,
	sps_cfg_if.sink  cfg
);

	localparam int CW = COORD_WIDTH;
	localparam int DW = DIST_WIDTH;
	localparam int AW = $clog2(NODES);
	localparam int WW = 2 * CW + 4;
	localparam int SW = ((DW > WW) ? DW : WW) + 1;
	localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;
	localparam int EW = PRED_W + DW;
	localparam count_t NODES_C = CNT_W'(NODES);
	localparam logic [DW-1:0] INF = '1;
	localparam logic [DW-1:0] SAT = {{(DW-1){1'b1}}, 1'b0};

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_E_RA = 5'd2;
	localparam logic [4:0] S_E_WA = 5'd3;
	localparam logic [4:0] S_E_RB = 5'd4;
	localparam logic [4:0] S_E_WB = 5'd5;
	localparam logic [4:0] S_SC_RD = 5'd6;
	localparam logic [4:0] S_SC_CMP = 5'd7;
	localparam logic [4:0] S_SC_END = 5'd8;
	localparam logic [4:0] S_RL_RD0 = 5'd9;
	localparam logic [4:0] S_RL_LAT = 5'd10;
	localparam logic [4:0] S_RL_RD = 5'd11;
	localparam logic [4:0] S_RL_WAIT = 5'd12;
	localparam logic [4:0] S_RL_MUL = 5'd13;
	localparam logic [4:0] S_RL_CMP = 5'd14;
	localparam logic [4:0] S_FIN_RD = 5'd15;
	localparam logic [4:0] S_FIN_CK = 5'd16;
	localparam logic [4:0] S_B_RD = 5'd17;
	localparam logic [4:0] S_B_WT = 5'd18;
	localparam logic [4:0] S_B_PUSHA = 5'd19;
	localparam logic [4:0] S_O_RD = 5'd20;
	localparam logic [4:0] S_O_PUT = 5'd21;
	localparam logic [4:0] S_STAT = 5'd22;

	// Memories: positions, adjacency rows, {predecessor, distance}, path stack.
	logic [3*CW-1:0] pos_mem [NODES];
	logic [NODES-1:0] adj_mem [NODES];
	logic [EW-1:0]    dist_mem [NODES];
	logic [AW-1:0]    stk_mem [NODES];

	logic [4:0]       state_q;
	count_t           node_count_q;
	count_t           cnt_q;
	cmd_t             cmd_q;
	node_t            a_q;
	node_t            b_q;
	logic [3*CW-1:0]  pin_q;
	logic [NODES-1:0] adj_valid_q;
	logic [NODES-1:0] dvalid_q;
	logic [NODES-1:0] visited_q;
	logic [AW-1:0]    i_q;
	logic [AW-1:0]    u_q;
	logic [AW-1:0]    n_q;
	logic [AW-1:0]    idx_q;
	count_t           len_q;
	logic [DW-1:0]    best_q;
	logic             found_q;
	logic [DW-1:0]    du_q;
	logic [DW-1:0]    di_q;
	logic [NODES-1:0] row_q;
	logic [3*CW-1:0]  pu_q;
	status_t          stat_q;

	logic [3*CW-1:0]  pos_rd_q;
	logic [NODES-1:0] adj_rd_q;
	logic             av_rd_q;
	logic [EW-1:0]    dist_rd_q;
	logic             dv_rd_q;
	logic [AW-1:0]    stk_rd_q;

	logic             rsp_valid_q;
	node_t            rsp_node_q;
	status_t          rsp_status_q;
	logic             rsp_last_q;

	logic             w_start;
	logic             w_done;
	logic [WW-1:0]    w_weight;

	logic [AW-1:0]    a_idx;
	logic [AW-1:0]    b_idx;
	logic [DW-1:0]    eff_dist;
	logic [PRED_W-1:0] eff_pred;
	logic [NODES-1:0] eff_row;
	logic             i_last;
	logic [SW-1:0]    sum;
	logic [DW-1:0]    nd;
	logic             rsp_free;
	logic             rsp_load;
	count_t           cnt_d;
	logic [XW-1:0]    xe;
	logic [XW-1:0]    ye;
	logic [XW-1:0]    ze;

	assign a_idx    = a_q[AW-1:0];
	assign b_idx    = b_q[AW-1:0];
	assign eff_dist = dv_rd_q ? dist_rd_q[DW-1:0] : INF;
	assign eff_pred = dv_rd_q ? dist_rd_q[EW-1:DW] : PRED_NONE;
	assign eff_row  = av_rd_q ? adj_rd_q : '0;
	assign i_last   = (CNT_W'(i_q) == cnt_q - 7'd1);
	assign sum      = SW'(du_q) + SW'(w_weight);
	assign nd       = (sum > SW'(SAT)) ? SAT : sum[DW-1:0];
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign rsp_load = rsp_free && (state_q == S_O_PUT || state_q == S_STAT);
	assign cnt_d    = (node_count_q > NODES_C) ? NODES_C : node_count_q;
	assign xe       = XW'($unsigned(req.pos_x));
	assign ye       = XW'($unsigned(req.pos_y));
	assign ze       = XW'($unsigned(req.pos_z));
	assign w_start  = (state_q == S_RL_WAIT);

	assign req.ready     = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.path_node = rsp_node_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.last      = rsp_last_q;

	sps_weight #(.CW(CW)) u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (w_start),
		.pos_a  (pu_q),
		.pos_b  (pos_rd_q),
		.done   (w_done),
		.weight (w_weight)
	);

	// Memory ports. The adjacency and distance reads register the matching valid bit with the data.
	always_ff @(posedge clk) begin
		if (state_q == S_DISP && cmd_q == CMD_SET_POS && CNT_W'(a_q) < NODES_C)
			pos_mem[a_idx] <= pin_q;
		if (state_q == S_RL_RD0)
			pos_rd_q <= pos_mem[u_q];
		else if (state_q == S_RL_RD)
			pos_rd_q <= pos_mem[i_q];

		case (state_q)
			S_E_RA: begin
				adj_rd_q <= adj_mem[a_idx];
				av_rd_q  <= adj_valid_q[a_idx];
			end
			S_E_RB: begin
				adj_rd_q <= adj_mem[b_idx];
				av_rd_q  <= adj_valid_q[b_idx];
			end
			S_RL_RD0: begin
				adj_rd_q <= adj_mem[u_q];
				av_rd_q  <= adj_valid_q[u_q];
			end
			default: ;
		endcase
		if (state_q == S_E_WA)
			adj_mem[a_idx] <= eff_row | (NODES'(1) << b_idx);
		else if (state_q == S_E_WB)
			adj_mem[b_idx] <= eff_row | (NODES'(1) << a_idx);

		case (state_q)
			S_SC_RD: begin
				dist_rd_q <= dist_mem[i_q];
				dv_rd_q   <= dvalid_q[i_q];
			end
			S_RL_RD: begin
				dist_rd_q <= dist_mem[i_q];
				dv_rd_q   <= dvalid_q[i_q];
			end
			S_FIN_RD: begin
				dist_rd_q <= dist_mem[b_idx];
				dv_rd_q   <= dvalid_q[b_idx];
			end
			S_B_RD: begin
				dist_rd_q <= dist_mem[n_q];
				dv_rd_q   <= dvalid_q[n_q];
			end
			default: ;
		endcase
		if (state_q == S_DISP)
			dist_mem[a_idx] <= {PRED_NONE, {DW{1'b0}}};
		else if (state_q == S_RL_CMP && nd < di_q)
			dist_mem[i_q] <= {PRED_W'(u_q), nd};

		if (state_q == S_B_WT)
			stk_mem[len_q[AW-1:0]] <= n_q;
		else if (state_q == S_B_PUSHA)
			stk_mem[len_q[AW-1:0]] <= a_idx;
		if (state_q == S_O_RD)
			stk_rd_q <= stk_mem[idx_q];
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.cmd;
			a_q   <= req.node_a;
			b_q   <= req.node_b;
			pin_q <= {ze[CW-1:0], ye[CW-1:0], xe[CW-1:0]};
		end
		case (state_q)
			S_DISP: begin
				cnt_q   <= cnt_d;
				i_q     <= '0;
				best_q  <= INF;
				found_q <= 1'b0;
				stat_q  <= (CNT_W'(a_q) >= cnt_d || CNT_W'(b_q) >= cnt_d) ?
					STAT_RANGE : STAT_NO_PATH;
			end
			S_SC_RD: begin
				if (visited_q[i_q] && !i_last) i_q <= i_q + 1'b1;
			end
			S_SC_CMP: begin
				if (eff_dist < best_q) begin
					best_q  <= eff_dist;
					u_q     <= i_q;
					found_q <= 1'b1;
				end
				if (!i_last) i_q <= i_q + 1'b1;
			end
			S_SC_END: du_q <= best_q;
			S_RL_LAT: begin
				row_q <= eff_row;
				pu_q  <= pos_rd_q;
				i_q   <= '0;
			end
			S_RL_RD: begin
				if (!(row_q[i_q] && !visited_q[i_q])) begin
					i_q <= i_last ? '0 : i_q + 1'b1;
					if (i_last) begin
						best_q  <= INF;
						found_q <= 1'b0;
					end
				end
			end
			S_RL_WAIT: di_q <= eff_dist;
			S_RL_CMP: begin
				i_q <= i_last ? '0 : i_q + 1'b1;
				if (i_last) begin
					best_q  <= INF;
					found_q <= 1'b0;
				end
			end
			S_FIN_CK: begin
				n_q   <= b_idx;
				len_q <= '0;
			end
			S_B_WT: begin
				len_q <= len_q + 7'd1;
				n_q   <= eff_pred[AW-1:0];
			end
			S_B_PUSHA: idx_q <= len_q[AW-1:0];
			S_O_PUT: begin
				if (rsp_free && idx_q != '0) idx_q <= idx_q - 1'b1;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= 7'd64;
			adj_valid_q  <= '0;
			dvalid_q     <= '0;
			visited_q    <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) node_count_q <= cfg.data;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (req.valid) state_q <= S_DISP;
				S_DISP: begin
					case (cmd_q)
						CMD_SET_POS: state_q <= S_IDLE;
						CMD_ADD_EDGE: state_q <= (CNT_W'(a_q) < NODES_C &&
							CNT_W'(b_q) < NODES_C) ? S_E_RA : S_IDLE;
						CMD_CLR_EDGE: begin
							adj_valid_q <= '0;
							state_q     <= S_IDLE;
						end
						default: begin
							if (CNT_W'(a_q) >= cnt_d || CNT_W'(b_q) >= cnt_d ||
								a_q == b_q) begin
								state_q <= S_STAT;
							end else begin
								dvalid_q  <= NODES'(1) << a_idx;
								visited_q <= '0;
								state_q   <= S_SC_RD;
							end
						end
					endcase
				end
				S_E_RA: state_q <= S_E_WA;
				S_E_WA: begin
					adj_valid_q[a_idx] <= 1'b1;
					state_q <= S_E_RB;
				end
				S_E_RB: state_q <= S_E_WB;
				S_E_WB: begin
					adj_valid_q[b_idx] <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SC_RD: begin
					if (!visited_q[i_q]) state_q <= S_SC_CMP;
					else if (i_last) state_q <= S_SC_END;
				end
				S_SC_CMP: state_q <= i_last ? S_SC_END : S_SC_RD;
				S_SC_END: begin
					if (!found_q || u_q == b_idx) begin
						state_q <= S_FIN_RD;
					end else begin
						visited_q[u_q] <= 1'b1;
						state_q <= S_RL_RD0;
					end
				end
				S_RL_RD0: state_q <= S_RL_LAT;
				S_RL_LAT: state_q <= S_RL_RD;
				S_RL_RD: begin
					if (row_q[i_q] && !visited_q[i_q]) state_q <= S_RL_WAIT;
					else if (i_last) state_q <= S_SC_RD;
				end
				S_RL_WAIT: state_q <= S_RL_MUL;
				S_RL_MUL: if (w_done) state_q <= S_RL_CMP;
				S_RL_CMP: begin
					if (nd < di_q) dvalid_q[i_q] <= 1'b1;
					state_q <= i_last ? S_SC_RD : S_RL_RD;
				end
				S_FIN_RD: state_q <= S_FIN_CK;
				S_FIN_CK: state_q <= (eff_pred == PRED_NONE) ? S_STAT : S_B_RD;
				S_B_RD: begin
					if (n_q == a_idx || len_q == PATH_MAX) state_q <= S_B_PUSHA;
					else state_q <= S_B_WT;
				end
				// A predecessor without a node ends the trace at the start.
				S_B_WT: state_q <= eff_pred[PRED_W-1] ? S_B_PUSHA : S_B_RD;
				S_B_PUSHA: state_q <= S_O_RD;
				S_O_RD: state_q <= S_O_PUT;
				S_O_PUT: if (rsp_free) state_q <= (idx_q == '0) ? S_IDLE : S_O_RD;
				S_STAT: if (rsp_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			if (state_q == S_STAT) begin
				rsp_node_q   <= '0;
				rsp_status_q <= stat_q;
				rsp_last_q   <= 1'b1;
			end else begin
				rsp_node_q   <= NODE_W'(stk_rd_q);
				rsp_status_q <= STAT_PATH;
				rsp_last_q   <= (idx_q == '0);
			end
		end
	end

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && rsp_valid_q) |-> rsp.ready)
		else $error("result register loaded while a transfer is pending");
	a_relax_from_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RL_CMP) |-> (visited_q[u_q] && visited_q[a_idx]))
		else $error("relaxation from a node that is not visited");
	a_start_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SC_CMP || state_q == S_RL_CMP) |-> dvalid_q[a_idx])
		else $error("start distance lost during search");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_B_PUSHA) |-> (len_q < NODES_C))
		else $error("path stack overflow");
`endif

endmodule
